/* rtl/imms_pkg.sv */
// shared constants for the interval min / max / mean statistics block
// no dependencies
package imms_pkg;

	localparam int DATA_W    = 32;	// sample and statistic field width
	localparam int CNT_OUT_W = 16;	// count field width

	// action codes carried on the input beat
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_FLUSH  = 1'b1;

endpackage

/* rtl/interval_min_max_mean_stats.sv */
// interval min / max / mean statistics, top level; depends on imms_pkg
// sample beats: folded into the accumulators at the accepting edge, one beat per cycle
// while idle (in_ready is low otherwise); flush: the restoring divider shifts one quotient
// bit per cycle over SUM_W = SAMPLE_WIDTH + COUNT_WIDTH (48 by default) dividend bits,
// an empty interval skips it; the result is registered, then new beats are accepted
// reset: arst_n clears the accumulators (min to most positive, max to most negative)
module interval_min_max_mean_stats #(
	parameter int SAMPLE_WIDTH = 32,
	parameter int COUNT_WIDTH  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic [imms_pkg::DATA_W-1:0]    sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [imms_pkg::DATA_W-1:0]    mean_out,
	output logic [imms_pkg::DATA_W-1:0]    max_out,
	output logic [imms_pkg::DATA_W-1:0]    min_out,
	output logic [imms_pkg::CNT_OUT_W-1:0] count_out,
	output logic                          saturated
);
	import imms_pkg::*;

	localparam int SW     = SAMPLE_WIDTH;
	localparam int CW     = COUNT_WIDTH;
	localparam int SUM_W  = SW + CW;	// wide enough for count * sample
	localparam int STEP_W = $clog2(SUM_W);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t state_q;

	// running accumulators
	logic [SW-1:0]    min_q;
	logic [SW-1:0]    max_q;
	logic [SUM_W-1:0] sum_q;
	logic [CW-1:0]    cnt_q;
	logic             drop_q;

	// snapshot of the interval taken at flush, held while dividing
	logic [SW-1:0]    snap_min_q;
	logic [SW-1:0]    snap_max_q;
	logic [CW-1:0]    snap_cnt_q;
	logic             snap_drop_q;
	logic             neg_q;

	// serial divider: dividend shifts out of quo_q msb first, quotient bits shift in
	logic [SUM_W-1:0]  quo_q;
	logic [CW-1:0]     rem_q;
	logic [STEP_W-1:0] step_q;

	// output register
	logic             out_valid_q;
	logic [DATA_W-1:0] mean_q;
	logic [DATA_W-1:0] max_out_q;
	logic [DATA_W-1:0] min_out_q;
	logic [CNT_OUT_W-1:0] count_q;
	logic             sat_q;

	logic             in_fire;
	logic             smp_fire;
	logic             fl_fire;
	logic [SW-1:0]    smp_v;
	logic [SUM_W-1:0] smp_ext;
	logic [SUM_W-1:0] sum_mag;
	logic [CW:0]      div_shift;
	logic [CW+1:0]    div_diff;
	logic             div_qbit;
	logic [SW-1:0]    quo_sw;
	logic [SW-1:0]    mean_sw;
	logic             out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign smp_fire  = in_fire && (action == ACT_SAMPLE);
	assign fl_fire   = in_fire && (action == ACT_FLUSH);
	assign out_free  = !out_valid_q || out_ready;

	// low SAMPLE_WIDTH bits of the port, zero filled above the port width
	assign smp_v   = SW'(sample);
	assign smp_ext = SUM_W'($signed(smp_v));

	// magnitude of the sum for an unsigned divide, sign restored at the end
	assign sum_mag = sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;

	// one restoring step: bring in the next dividend bit, trial subtract
	assign div_shift = {rem_q, quo_q[SUM_W-1]};
	assign div_diff  = {1'b0, div_shift} - (CW+2)'(snap_cnt_q);
	assign div_qbit  = !div_diff[CW+1];

	// mean fits in the sample width, so the quotient is negated there
	assign quo_sw  = quo_q[SW-1:0];
	assign mean_sw = neg_q ? (~quo_sw + SW'(1)) : quo_sw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			min_q       <= {1'b0, {(SW-1){1'b1}}};
			max_q       <= {1'b1, {(SW-1){1'b0}}};
			sum_q       <= '0;
			cnt_q       <= '0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
			mean_q      <= '0;
			max_out_q   <= '0;
			min_out_q   <= '0;
			count_q     <= '0;
			sat_q       <= 1'b0;
		end else begin
			// in ST_DONE the result load below decides the output valid
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (smp_fire) begin
						if (cnt_q == '1) begin
							// count full: sample dropped, only the flag moves
							drop_q <= 1'b1;
						end else begin
							if ($signed(smp_v) < $signed(min_q)) begin
								min_q <= smp_v;
							end
							if ($signed(smp_v) > $signed(max_q)) begin
								max_q <= smp_v;
							end
							sum_q <= sum_q + smp_ext;
							cnt_q <= cnt_q + CW'(1);
						end
					end else if (fl_fire) begin
						// snapshot goes to the divider, accumulators start over
						min_q  <= {1'b0, {(SW-1){1'b1}}};
						max_q  <= {1'b1, {(SW-1){1'b0}}};
						sum_q  <= '0;
						cnt_q  <= '0;
						drop_q <= 1'b0;
						// empty interval needs no divide
						state_q <= (cnt_q == '0) ? ST_DONE : ST_DIV;
					end
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						count_q     <= CNT_OUT_W'(snap_cnt_q);
						sat_q       <= snap_drop_q;
						if (snap_cnt_q == '0) begin
							mean_q    <= '0;
							max_out_q <= '0;
							min_out_q <= '0;
						end else begin
							mean_q    <= DATA_W'($signed(mean_sw));
							max_out_q <= DATA_W'($signed(snap_max_q));
							min_out_q <= DATA_W'($signed(snap_min_q));
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// divider datapath and interval snapshot
	always_ff @(posedge clk) begin
		if (fl_fire) begin
			snap_min_q  <= min_q;
			snap_max_q  <= max_q;
			snap_cnt_q  <= cnt_q;
			snap_drop_q <= drop_q;
			neg_q       <= sum_q[SUM_W-1];
			quo_q       <= sum_mag;
			rem_q       <= '0;
			step_q      <= STEP_W'(SUM_W - 1);
		end else if (state_q == ST_DIV) begin
			rem_q  <= div_qbit ? div_diff[CW-1:0] : div_shift[CW-1:0];
			quo_q  <= {quo_q[SUM_W-2:0], div_qbit};
			step_q <= step_q - STEP_W'(1);
		end
	end

	assign out_valid = out_valid_q;
	assign mean_out  = mean_q;
	assign max_out   = max_out_q;
	assign min_out   = min_out_q;
	assign count_out = count_q;
	assign saturated = sat_q;

endmodule

/* test/interval_min_max_mean_stats_tb.sv */
// self-checking testbench for interval_min_max_mean_stats: sample and flush beats
// are checked against an in-bench predictor of the running min / max / sum / count
// depends on imms_pkg and rtl/interval_min_max_mean_stats.sv
module interval_min_max_mean_stats_tb;

	import imms_pkg::*;

	localparam int                 SUM_W     = 48;
	localparam logic [CNT_OUT_W-1:0] CNT_FULL = '1;
	localparam logic [DATA_W-1:0]  MOST_POS  = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0]  MOST_NEG  = {1'b1, {(DATA_W-1){1'b0}}};

	// one input beat plus how the driver should treat it
	typedef struct {
		logic              act;
		logic [DATA_W-1:0] smp;
		bit                drain;	// hold this beat until no flush result is outstanding
		bit                calm;	// no idling on either side while this beat is around
	} beat_t;

	// one flush result
	typedef struct {
		logic [DATA_W-1:0]    mean;
		logic [DATA_W-1:0]    max;
		logic [DATA_W-1:0]    min;
		logic [CNT_OUT_W-1:0] count;
		logic                 sat;
	} stats_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 action = ACT_SAMPLE;
	logic [DATA_W-1:0]    sample = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [DATA_W-1:0]    mean_out;
	logic [DATA_W-1:0]    max_out;
	logic [DATA_W-1:0]    min_out;
	logic [CNT_OUT_W-1:0] count_out;
	logic                 saturated;

	interval_min_max_mean_stats u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.sample    (sample),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.mean_out  (mean_out),
		.max_out   (max_out),
		.min_out   (min_out),
		.count_out (count_out),
		.saturated (saturated)
	);

	// free-running clock, period 12
	initial begin
		forever #6 clk = ~clk;
	end

	// reset held low, released away from the active edge
	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// ------------------------------------------------------------------
	// predictor state: the interval accumulators as the block should hold them
	// ------------------------------------------------------------------
	logic signed [DATA_W-1:0] acc_min = MOST_POS;
	logic signed [DATA_W-1:0] acc_max = MOST_NEG;
	logic signed [SUM_W-1:0]  acc_sum = '0;
	logic [CNT_OUT_W-1:0]     acc_cnt = '0;
	logic                     acc_dropped = 1'b0;

	beat_t  beats_todo[$];	// beats not yet offered to the block
	stats_t stats_due[$];	// flush results predicted but not yet seen
	int     beats_total = -1;
	int     beats_taken = 0;
	int     mismatch_count = 0;
	int     flushes_seen = 0;

	// fold one sample into the interval; once the count is full the sample
	// only marks the interval as having dropped data
	task automatic fold_sample(input logic [DATA_W-1:0] raw);
		logic signed [DATA_W-1:0] s;
		s = $signed(raw);
		if (acc_cnt == CNT_FULL) begin
			acc_dropped = 1'b1;
		end else begin
			if (s < acc_min) acc_min = s;
			if (s > acc_max) acc_max = s;
			acc_sum = acc_sum + s;
			acc_cnt = acc_cnt + 1'b1;
		end
	endtask

	// statistics of the closing interval, then clear for the next one
	function automatic stats_t close_interval();
		stats_t r;
		longint q;
		if (acc_cnt != 0) begin
			// signed longint division truncates toward zero
			q      = longint'(acc_sum) / longint'(acc_cnt);
			r.mean = q[DATA_W-1:0];
			r.max  = acc_max;
			r.min  = acc_min;
		end else begin
			r.mean = '0;
			r.max  = '0;
			r.min  = '0;
		end
		r.count     = acc_cnt;
		r.sat       = acc_dropped;
		acc_min     = MOST_POS;
		acc_max     = MOST_NEG;
		acc_sum     = '0;
		acc_cnt     = '0;
		acc_dropped = 1'b0;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		$display("mismatch at flush result %0d: %s got %08h want %08h",
			flushes_seen, what, got, want);
		mismatch_count++;
	endtask

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_beat(input logic act, input logic [DATA_W-1:0] smp,
			input bit drain, input bit calm);
		beat_t b;
		b.act   = act;
		b.smp   = smp;
		b.drain = drain;
		b.calm  = calm;
		beats_todo.push_back(b);
	endtask

	// mix of extremes, values near zero and full-range noise
	function automatic logic [DATA_W-1:0] pick_sample();
		int unsigned kind;
		kind = $urandom_range(0, 9);
		case (kind)
			0: begin
				return MOST_POS;
			end
			1: begin
				return MOST_NEG;
			end
			2: begin
				return DATA_W'($signed($urandom_range(0, 200)) - 100);
			end
			3: begin
				return {DATA_W{kind[0]}};
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// driver: offers beats from beats_todo, predicts on every accepted beat
	// ------------------------------------------------------------------
	int    idle_left = 0;
	bit    gaps_off = 1'b0;	// set while calm beats are in flight, read by the monitor
	beat_t drv_next;
	stats_t drv_stats;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			action    <= ACT_SAMPLE;
			sample    <= '0;
			idle_left <= 0;
			gaps_off  <= 1'b0;
		end else begin
			// beat taken at this edge: run it through the predictor
			if (in_valid && in_ready) begin
				beats_taken <= beats_taken + 1;
				if (action == ACT_FLUSH) begin
					drv_stats = close_interval();
					stats_due.push_back(drv_stats);
				end else begin
					fold_sample(sample);
				end
			end
			// the channel is free when nothing is offered or the offer just went
			if (!in_valid || in_ready) begin
				if (idle_left > 0) begin
					in_valid  <= 1'b0;
					idle_left <= idle_left - 1;
				end else if (beats_todo.size() == 0) begin
					in_valid <= 1'b0;
				end else if (beats_todo[0].drain && stats_due.size() != 0) begin
					// pause until every outstanding flush result has come back
					in_valid <= 1'b0;
				end else if (!beats_todo[0].calm && $urandom_range(0, 5) == 0) begin
					// random idle burst
					in_valid  <= 1'b0;
					idle_left <= $urandom_range(0, 15);
				end else begin
					drv_next = beats_todo.pop_front();
					in_valid <= 1'b1;
					action   <= drv_next.act;
					sample   <= drv_next.smp;
					gaps_off <= drv_next.calm;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: random backpressure, checks each result against the oldest prediction
	// ------------------------------------------------------------------
	int     stall_left = 0;
	stats_t mon_want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				flushes_seen <= flushes_seen + 1;
				if (stats_due.size() == 0) begin
					report_mismatch("unexpected result, mean", mean_out, '0);
				end else begin
					mon_want = stats_due.pop_front();
					if (mean_out !== mon_want.mean)
						report_mismatch("mean_out", mean_out, mon_want.mean);
					if (max_out !== mon_want.max)
						report_mismatch("max_out", max_out, mon_want.max);
					if (min_out !== mon_want.min)
						report_mismatch("min_out", min_out, mon_want.min);
					if (count_out !== mon_want.count)
						report_mismatch("count_out", DATA_W'(count_out), DATA_W'(mon_want.count));
					if (saturated !== mon_want.sat)
						report_mismatch("saturated", DATA_W'(saturated), DATA_W'(mon_want.sat));
				end
			end
			if (stall_left > 0) begin
				out_ready  <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (!gaps_off && $urandom_range(0, 5) == 0) begin
				// random stall burst
				out_ready  <= 1'b0;
				stall_left <= $urandom_range(0, 15);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		int  made;
		int  len;
		int  pick;
		bit  calm_run;

		// directed: empty flush with a nonzero sample field that must be ignored
		push_beat(ACT_FLUSH, 32'hDEAD_BEEF, 1'b0, 1'b0);
		// both extremes: sum of -1 over two samples truncates to zero
		push_beat(ACT_SAMPLE, MOST_POS, 1'b0, 1'b0);
		push_beat(ACT_SAMPLE, MOST_NEG, 1'b0, 1'b0);
		push_beat(ACT_FLUSH, '0, 1'b0, 1'b0);
		// negative mean rounds toward zero: -5 / 2 gives -2
		push_beat(ACT_SAMPLE, -32'sd7, 1'b0, 1'b0);
		push_beat(ACT_SAMPLE, 32'sd2, 1'b0, 1'b0);
		push_beat(ACT_FLUSH, '1, 1'b0, 1'b0);
		// back-to-back flushes, the second one after the first result is back
		push_beat(ACT_FLUSH, '0, 1'b1, 1'b0);
		push_beat(ACT_FLUSH, 32'h5555_5555, 1'b1, 1'b0);
		// sums beyond the sample width in both directions
		repeat (3) push_beat(ACT_SAMPLE, MOST_POS, 1'b0, 1'b0);
		push_beat(ACT_FLUSH, 32'hAAAA_AAAA, 1'b0, 1'b0);
		repeat (3) push_beat(ACT_SAMPLE, MOST_NEG, 1'b0, 1'b0);
		push_beat(ACT_FLUSH, '0, 1'b0, 1'b0);
		// single zero sample, positive truncation
		push_beat(ACT_SAMPLE, '0, 1'b0, 1'b0);
		push_beat(ACT_FLUSH, '1, 1'b1, 1'b0);
		push_beat(ACT_SAMPLE, 32'sd5, 1'b0, 1'b0);
		push_beat(ACT_SAMPLE, 32'sd6, 1'b0, 1'b0);
		push_beat(ACT_FLUSH, '0, 1'b0, 1'b0);

		// random intervals of mostly short, sometimes long, length
		made     = 0;
		calm_run = 1'b0;
		while (made < 920) begin
			if ($urandom_range(0, 5) == 0)
				calm_run = !calm_run;
			pick = $urandom_range(0, 9);
			if (pick < 2)
				len = 0;
			else if (pick < 8)
				len = $urandom_range(1, 12);
			else
				len = $urandom_range(13, 60);
			repeat (len) push_beat(ACT_SAMPLE, pick_sample(), 1'b0, calm_run);
			push_beat(ACT_FLUSH, $urandom, $urandom_range(0, 9) == 0, calm_run);
			made += len + 1;
		end

		// closing part, no idling on either side
		repeat (40) push_beat(ACT_SAMPLE, pick_sample(), 1'b0, 1'b1);
		push_beat(ACT_FLUSH, '0, 1'b0, 1'b1);
		// the next interval must start clean
		push_beat(ACT_SAMPLE, -32'sd3, 1'b1, 1'b1);
		push_beat(ACT_FLUSH, '0, 1'b0, 1'b1);

		beats_total = beats_todo.size();

		wait (arst_n);
		wait (beats_taken == beats_total);
		while (stats_due.size() != 0)
			@(posedge clk);
		// give stray results time to show up
		repeat (SUM_W + 16) @(posedge clk);
		if (mismatch_count == 0 && stats_due.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#12_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

/* sim.f */
rtl/imms_pkg.sv
rtl/interval_min_max_mean_stats.sv
test/interval_min_max_mean_stats_tb.sv
